>>> src/des_pkg.sv
// ----------------------------------------------------------------------------
// Descending exchange sorter package
// Types and constants shared by the sorter top level and its insertion cells.
// ----------------------------------------------------------------------------
package des_pkg;

    localparam int DATA_W = 16;

    // Values at or above this limit are refused and never stored.
    localparam int REJECT_LIMIT = 256;

    typedef logic signed [DATA_W-1:0] t_value;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;    // insert the broadcast value into the sorted row
        logic shift;  // move every entry one cell toward the head
    } t_cell_ctl;

endpackage

>>> src/descending_exchange_sorter.sv
// ----------------------------------------------------------------------------
// Descending exchange sorter
// Collects a batch of signed values and returns it ordered from largest to
// smallest, refusing values of 256 and above.
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata               | tlast          | tuser
//  ---------+-----+---------------------+----------------+----------
//  s_axis   | in  | value [15:0]        | last_of_batch  | -
//  m_axis   | out | sorted_value [15:0] | last_of_run    | rejected
//
// Each accepted value is placed into a row of MAX_COUNT insertion cells as
// it is taken, so loading runs at one request per clock while the output
// register is free. A batch closes on a stored value marked last or when
// the row holds MAX_COUNT values; the row then drains from its head, one
// sorted result per cycle while the output register is free. Input is held
// off during the drain. A refused value is answered with one rejected result
// through the same output register. A request is taken only when the output
// register is empty or its result leaves in the same cycle, so a stalled
// output holds off the input. Reset is synchronous and active low; it
// empties the row and the output register. No clearing pass is needed.
//
module descending_exchange_sorter #(
    parameter int MAX_COUNT = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] value
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] sorted_value
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // [0] rejected
);
    import des_pkg::*;

    localparam int CNT_W = $clog2(MAX_COUNT + 1);

    typedef enum logic [1:0] {
        ST_LOAD  = 2'b01,
        ST_DRAIN = 2'b10
    } t_state;

    t_state     r_state;
    t_state     n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    logic       r_out_valid;
    logic       n_out_valid;
    t_value     r_out_data;
    t_value     n_out_data;
    logic       r_out_last;
    logic       n_out_last;
    logic       r_out_rej;
    logic       n_out_rej;

    t_cell_ctl  w_ctl;
    t_value     w_x;
    logic       w_out_free;
    logic       w_accept;
    logic       w_is_rej;
    logic       w_close;
    logic       w_pop;

    t_value     w_val [MAX_COUNT];
    logic       w_vld [MAX_COUNT];
    logic       w_gt  [MAX_COUNT];

    assign w_x        = t_value'(s_axis_tdata);
    assign w_out_free = !r_out_valid || m_axis_tready;

    // Loading only while the output register can take a possible reject.
    assign s_axis_tready = (r_state == ST_LOAD) && w_out_free;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // A non-negative value with any bit set from REJECT_LIMIT upward is refused.
    assign w_is_rej = !w_x[DATA_W-1] && (w_x[DATA_W-2:$clog2(REJECT_LIMIT)] != '0);

    // The batch closes on a marked request or on the one that fills the row.
    assign w_close = s_axis_tlast || (r_count == CNT_W'(MAX_COUNT - 1));

    assign w_pop     = (r_state == ST_DRAIN) && w_out_free;
    assign w_ctl.ins   = w_accept && !w_is_rej;
    assign w_ctl.shift = w_pop;

    // Row of insertion cells; cell 0 holds the largest value.
    for (genvar g = 0; g < MAX_COUNT; g++) begin : g_cell
        t_value w_left_val;
        logic   w_left_vld;
        logic   w_left_gt;
        t_value w_right_val;
        logic   w_right_vld;

        if (g == 0) begin : g_head
            assign w_left_val = '0;
            assign w_left_vld = 1'b0;
            assign w_left_gt  = 1'b0;
        end else begin : g_body
            assign w_left_val = w_val[g-1];
            assign w_left_vld = w_vld[g-1];
            assign w_left_gt  = w_gt[g-1];
        end

        if (g == MAX_COUNT - 1) begin : g_tail
            assign w_right_val = '0;
            assign w_right_vld = 1'b0;
        end else begin : g_inner
            assign w_right_val = w_val[g+1];
            assign w_right_vld = w_vld[g+1];
        end

        des_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_x         (w_x),
            .i_left_val  (w_left_val),
            .i_left_vld  (w_left_vld),
            .i_left_gt   (w_left_gt),
            .i_right_val (w_right_val),
            .i_right_vld (w_right_vld),
            .o_val       (w_val[g]),
            .o_vld       (w_vld[g]),
            .o_gt        (w_gt[g])
        );
    end

    // Sequencing of load and drain, and the output register.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        n_out_rej   = r_out_rej;

        if (w_out_free) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_LOAD: begin
                if (w_accept) begin
                    if (w_is_rej) begin
                        n_out_valid = 1'b1;
                        n_out_data  = '0;
                        n_out_last  = 1'b0;
                        n_out_rej   = 1'b1;
                    end else if (w_close) begin
                        n_state = ST_DRAIN;
                        n_count = '0;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
            end
            ST_DRAIN: begin
                if (w_pop) begin
                    // The row holds at least one value for every pop issued.
                    n_out_valid = 1'b1;
                    n_out_data  = w_val[0];
                    n_out_last  = !w_vld[1];
                    n_out_rej   = 1'b0;
                    if (!w_vld[1]) begin
                        n_state = ST_LOAD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
        r_out_rej  <= n_out_rej;
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_rej;

`ifndef SYNTHESIS
    // The fill count never reaches capacity: the filling request closes the batch.
    a_count_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < CNT_W'(MAX_COUNT))
        else $error("fill count reached capacity");

    // A refused request shows up as a rejected result on the next cycle.
    a_reject_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_is_rej) |=> (m_axis_tvalid && m_axis_tuser && !m_axis_tlast))
        else $error("rejected request not answered");

    // While draining, the head cell always holds a value.
    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> w_vld[0])
        else $error("drain with an empty row");

    // After the final sorted result leaves the row, the row is empty.
    a_row_empty_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_vld[1]) |=> (!w_vld[0] && r_state == ST_LOAD))
        else $error("row not empty after final result");
`endif

endmodule

>>> src/des_cell.sv
// ----------------------------------------------------------------------------
// Descending sorter insertion cell
// One slot of the sorted row: holds a value and its valid bit, takes the new
// value or its left neighbor's entry on insert, and its right neighbor's
// entry on shift.
// ----------------------------------------------------------------------------
module des_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  des_pkg::t_cell_ctl i_ctl,
    input  des_pkg::t_value    i_x,
    input  des_pkg::t_value    i_left_val,
    input  logic               i_left_vld,
    input  logic               i_left_gt,
    input  des_pkg::t_value    i_right_val,
    input  logic               i_right_vld,
    output des_pkg::t_value    o_val,
    output logic               o_vld,
    output logic               o_gt
);
    import des_pkg::*;

    t_value r_val;
    t_value n_val;
    logic   r_vld;
    logic   n_vld;
    logic   w_gt;

    // The new value belongs at or before this slot when the slot is empty or
    // holds a smaller value. Along the row this flag is monotone.
    assign w_gt = !r_vld || (i_x > r_val);

    always_comb begin
        n_val = r_val;
        n_vld = r_vld;
        if (i_ctl.shift) begin
            n_val = i_right_val;
            n_vld = i_right_vld;
        end else if (i_ctl.ins && w_gt) begin
            if (i_left_gt) begin
                n_val = i_left_val;
                n_vld = i_left_vld;
            end else begin
                n_val = i_x;
                n_vld = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_val = r_val;
    assign o_vld = r_vld;
    assign o_gt  = w_gt;

endmodule
